// ----- hdl/wsc_pkg.sv -----
// Package for the wavetable sound channel: request codes, widths, limits
// and the command word passed from the issue stage to the accumulate stage.
// No dependencies.
`default_nettype none
package wsc_pkg;

    localparam int BANK_BYTES  = 16;
    localparam int STORE_BYTES = 2 * BANK_BYTES;
    localparam int BYTE_AW     = $clog2(BANK_BYTES);
    localparam int STORE_AW    = $clog2(STORE_BYTES);

    localparam logic [8:0]  LEN_FULL  = 9'd256;
    localparam logic [11:0] SUM_MAX   = 12'd4095;
    localparam logic [7:0]  COUNT_MAX = 8'd255;

    localparam int IN_BYTES  = 2;
    localparam int OUT_BYTES = 3;

    typedef enum logic [2:0] {
        REQ_CTRL    = 3'd0,
        REQ_TRIGGER = 3'd1,
        REQ_WAVE    = 3'd2,
        REQ_LENGTH  = 3'd3,
        REQ_SAMPLE  = 3'd4
    } wsc_req_t;

    typedef enum logic [1:0] {
        CFG_SOUND_LENGTH = 2'd0,
        CFG_VOLUME_CODE  = 2'd1,
        CFG_FORCE_3Q     = 2'd2
    } wsc_cfg_t;

    typedef enum logic [1:0] {
        VOL_MUTE    = 2'd0,
        VOL_FULL    = 2'd1,
        VOL_HALF    = 2'd2,
        VOL_QUARTER = 2'd3
    } wsc_vol_t;

    // Command from the issue stage to the accumulate stage
    typedef struct packed {
        logic clr;      // clear sum and count
        logic add;      // add the fetched sample
        logic lo_nib;   // take the low nibble of the fetched byte
        logic on;       // playing flag after this item
        logic changed;  // playing flag toggled by this item
    } wsc_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/wavetable_sound_channel.sv -----
// Wavetable sound channel top level: issue stage, wave memory, accumulate
// stage and output register. Depends on wsc_pkg.
//
// Usage:
//   Items arrive as beats on the s_ channel (req_type on s_tuser, ram_index
//   and write_data packed in s_tdata). Every accepted beat yields exactly one
//   result beat on the m_ channel (sample_sum, samples_summed, channel_on,
//   enable_changed packed in m_tdata), in order.
//   Registers sound_length, volume_code and force_three_quarter are written
//   through cfg_wr_en / cfg_index / cfg_wdata; the user must write them only
//   while the channel is idle, as the block itself does not enforce it. An
//   accepted beat is registered in the accumulate stage, then in the output
//   register. Throughput: one beat per cycle while the receiver takes results;
//   the wave memory has one write and one registered read port, and control
//   state is updated at acceptance. A wave write is seen by a later fetch.
//   Reset (aresetn low, synchronous) clears all control state, counters,
//   registers and the per-byte valid bits; an unwritten byte reads as zero.
//   When the receiver stalls, the output register holds its beat, the
//   accumulate stage holds its item, and s_tready drops once both are full.
`default_nettype none
module wavetable_sound_channel
    import wsc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration
    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [7:0]             cfg_wdata,
    // input items
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [3:0] ram_index, [11:4] write_data, [15:12] zero
    input  wire logic [8*IN_BYTES-1:0]  s_tdata,
    // [2:0] req_type
    input  wire logic [2:0]             s_tuser,
    // results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [11:0] sample_sum, [19:12] samples_summed, [20] channel_on,
    // [21] enable_changed, [23:22] zero
    output logic [8*OUT_BYTES-1:0]      m_tdata
);

    // configuration registers
    logic [7:0] sound_length_reg;
    logic [1:0] volume_code_reg;
    logic       force_3q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sound_length_reg <= '0;
            volume_code_reg  <= '0;
            force_3q_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (wsc_cfg_t'(cfg_index))
                CFG_SOUND_LENGTH: sound_length_reg <= cfg_wdata;
                CFG_VOLUME_CODE:  volume_code_reg  <= cfg_wdata[1:0];
                CFG_FORCE_3Q:     force_3q_reg     <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // unpack input beat
    logic [2:0]         req_type;
    logic [BYTE_AW-1:0] ram_index;
    logic [7:0]         write_data;

    assign req_type   = s_tuser;
    assign ram_index  = s_tdata[0 +: BYTE_AW];
    assign write_data = s_tdata[BYTE_AW +: 8];

    // pipeline handshakes
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg;
    logic s1_adv;
    logic accept;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // control state, updated at acceptance
    logic [4:0] pos_reg, pos_next;
    logic       play_bank_reg, play_bank_next;
    logic       select_bank_reg, select_bank_next;
    logic       two_bank_reg, two_bank_next;
    logic       dac_on_reg, dac_on_next;
    logic       playing_reg, playing_next;
    logic       stop_mode_reg, stop_mode_next;
    logic [8:0] len_count_reg, len_count_next;
    logic       tick_phase_reg, tick_phase_next;

    wsc_cmd_t           cmd;
    logic               mem_we;
    logic [STORE_AW-1:0] mem_waddr;
    logic               mem_re;
    logic [STORE_AW-1:0] mem_raddr;
    logic [8:0]         len_inc;

    assign len_inc   = (len_count_reg < LEN_FULL) ? len_count_reg + 9'd1 : LEN_FULL;
    assign mem_waddr = {~select_bank_reg, ram_index};
    assign mem_raddr = {play_bank_reg, pos_reg[4:1]};

    always_comb begin
        pos_next         = pos_reg;
        play_bank_next   = play_bank_reg;
        select_bank_next = select_bank_reg;
        two_bank_next    = two_bank_reg;
        dac_on_next      = dac_on_reg;
        playing_next     = playing_reg;
        stop_mode_next   = stop_mode_reg;
        len_count_next   = len_count_reg;
        tick_phase_next  = tick_phase_reg;
        cmd              = '0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        unique case (req_type)
            REQ_CTRL: begin
                two_bank_next    = write_data[5];
                select_bank_next = write_data[6];
                dac_on_next      = write_data[7];
                // DAC switched off: stop and clear the sum
                if (!write_data[7] && dac_on_reg) begin
                    playing_next = 1'b0;
                    cmd.clr      = 1'b1;
                end
                play_bank_next = write_data[6];
                pos_next       = '0;
            end
            REQ_TRIGGER: begin
                stop_mode_next = write_data[6];
                if (write_data[7]) begin
                    cmd.clr = 1'b1;
                    if (dac_on_reg) begin
                        playing_next   = 1'b1;
                        len_count_next = LEN_FULL - {1'b0, sound_length_reg};
                        pos_next       = '0;
                        play_bank_next = select_bank_reg;
                    end
                end
            end
            REQ_WAVE: begin
                mem_we = 1'b1;
            end
            REQ_LENGTH: begin
                if (playing_reg) begin
                    if (tick_phase_reg && stop_mode_reg) begin
                        len_count_next = len_inc;
                        if (len_inc[8]) begin
                            playing_next = 1'b0;
                        end
                    end
                    tick_phase_next = ~tick_phase_reg;
                    // length expiry clears the sum
                    if (!playing_next) begin
                        cmd.clr = 1'b1;
                    end
                end
            end
            REQ_SAMPLE: begin
                if (playing_reg) begin
                    mem_re     = 1'b1;
                    cmd.add    = 1'b1;
                    cmd.lo_nib = pos_reg[0];
                    pos_next   = pos_reg + 5'd1;
                    // wrap: swap banks in two-bank mode
                    if (pos_reg == 5'd31 && two_bank_reg) begin
                        play_bank_next = ~play_bank_reg;
                    end
                end
            end
            default: ;
        endcase

        cmd.on      = playing_next;
        cmd.changed = playing_next ^ playing_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            play_bank_reg   <= 1'b0;
            select_bank_reg <= 1'b0;
            two_bank_reg    <= 1'b0;
            dac_on_reg      <= 1'b0;
            playing_reg     <= 1'b0;
            stop_mode_reg   <= 1'b0;
            len_count_reg   <= '0;
            tick_phase_reg  <= 1'b0;
        end else if (accept) begin
            pos_reg         <= pos_next;
            play_bank_reg   <= play_bank_next;
            select_bank_reg <= select_bank_next;
            two_bank_reg    <= two_bank_next;
            dac_on_reg      <= dac_on_next;
            playing_reg     <= playing_next;
            stop_mode_reg   <= stop_mode_next;
            len_count_reg   <= len_count_next;
            tick_phase_reg  <= tick_phase_next;
        end
    end

    // wave memory: one write port, one registered read port
    logic [7:0]             wave_mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] byte_valid_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (accept && mem_we) begin
            wave_mem[mem_waddr] <= write_data;
        end
        if (accept && mem_re) begin
            rd_data_reg <= wave_mem[mem_raddr];
        end
    end

    // unwritten bytes read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end else if (accept) begin
            if (mem_we) begin
                byte_valid_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re) begin
                rd_valid_reg <= byte_valid_reg[mem_raddr];
            end
        end
    end

    // accumulate stage
    wsc_cmd_t s1_cmd_reg;

    assign s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg <= cmd;
        end
    end

    logic [3:0]  nibble;
    logic [5:0]  triple;
    logic [3:0]  scaled;
    logic [12:0] sum_wide;
    logic [11:0] sum_reg, sum_next;
    logic [7:0]  count_reg, count_next;

    assign nibble = !rd_valid_reg ? 4'd0
                  : (s1_cmd_reg.lo_nib ? rd_data_reg[3:0] : rd_data_reg[7:4]);
    assign triple = {2'b00, nibble} + {1'b0, nibble, 1'b0};

    always_comb begin
        if (force_3q_reg) begin
            scaled = triple[5:2];
        end else begin
            unique case (wsc_vol_t'(volume_code_reg))
                VOL_MUTE:    scaled = 4'd0;
                VOL_FULL:    scaled = nibble;
                VOL_HALF:    scaled = nibble >> 1;
                VOL_QUARTER: scaled = nibble >> 2;
                default:     scaled = 4'd0;
            endcase
        end
    end

    assign sum_wide = {1'b0, sum_reg} + {9'd0, scaled};

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (s1_cmd_reg.clr) begin
            sum_next   = '0;
            count_next = '0;
        end else if (s1_cmd_reg.add) begin
            sum_next   = sum_wide[12] ? SUM_MAX : sum_wide[11:0];
            count_next = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (s1_adv) begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // output register
    logic [8*OUT_BYTES-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= {2'b00, s1_cmd_reg.changed, s1_cmd_reg.on, count_next, sum_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ----- hdl/wsc_checker.sv -----
// Port-level checker for the wavetable sound channel, bound to the top level.
// Depends on wsc_pkg.
`default_nettype none
module wsc_checker
    import wsc_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [8*OUT_BYTES-1:0] m_tdata
);

    // a stalled beat holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an empty sum is zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19:12] == 8'd0 |-> m_tdata[11:0] == 12'd0)
        else $error("nonzero sum with zero count");

    // switching off clears the sum and count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] && !m_tdata[20] |-> m_tdata[19:0] == 20'd0)
        else $error("sum not cleared when channel stopped");

    // switching on comes from a trigger, which clears the sum
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] && m_tdata[20] |-> m_tdata[19:12] == 8'd0)
        else $error("count not cleared on trigger");

endmodule

bind wavetable_sound_channel wsc_checker u_wsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
